FILE: hw/rtl/krq_pkg.sv
// Package for the keyed registry and two-class queue unit.
// Holds the record type, opcodes, status codes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
package krq_pkg;

    localparam int RecWidth = 50;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] src;
        logic [15:0] dst;
        logic [1:0]  prio;
    } rec_t;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_SEARCH  = 3'd1,
        OP_DELETE  = 3'd2,
        OP_ENQUEUE = 3'd3,
        OP_DELIVER = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NOT_FOUND   = 3'd1,
        ST_REG_FULL    = 3'd2,
        ST_QUEUE_FULL  = 3'd3,
        ST_QUEUE_EMPTY = 3'd4
    } status_t;

    localparam logic [1:0] HighPrio = 2'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_QRD,
        S_QWAIT,
        S_DONE
    } state_t;

endpackage

FILE: hw/rtl/krq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module krq_ram #(
    parameter int WIDTH = 50,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/keyed_registry_two_class_queue_unit.sv
// Top level of the keyed registry and two-class queue unit.
// Holds the sequencer, one key comparator and two RAM instances (krq_ram);
// uses krq_pkg.
//
// Usage: s_ channel carries one operation (add, search, delete, enqueue,
// deliver); m_ channel returns exactly one result per operation with a status
// and the record concerned. s_ready is high only while the sequencer is idle.
// Steps per operation, from acceptance to m_valid:
//   add, unused opcodes, deliver from an empty queue: straight to S_DONE
//   search/enqueue: S_SCAN_RD and S_SCAN_CMP for each entry up to the match,
//   or for every entry on a miss (one comparator)
//   delete: the search, then S_SHIFT_RD and S_SHIFT_WR per record moved down
//   deliver: S_QRD and S_QWAIT (one queue RAM read)
// The registry is scanned one entry at a time through its one read port;
// this comparator loop sets the rate; one operation is in flight at a time.
// The next operation is taken the cycle after the result is accepted.
// Reset empties registry and queue (counts and head cleared); RAM contents
// are left as they are. When the receiver stalls the result is held in the
// output register and no new operation is taken until it is accepted.
`timescale 1ns / 1ps
module keyed_registry_two_class_queue_unit #(
    parameter int REGISTRY_DEPTH = 16,
    parameter int QUEUE_DEPTH    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [15:0] s_key_id,
    input  logic [15:0] s_source_loc,
    input  logic [15:0] s_dest_loc,
    input  logic [1:0]  s_prio_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_res_id,
    output logic [15:0] m_res_source,
    output logic [15:0] m_res_dest,
    output logic [1:0]  m_res_prio
);

    localparam int RAW = $clog2(REGISTRY_DEPTH);
    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int RCW = $clog2(REGISTRY_DEPTH + 1);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [RCW-1:0] RegFull = RCW'(REGISTRY_DEPTH);
    localparam logic [QCW-1:0] QueFull = QCW'(QUEUE_DEPTH);

    krq_pkg::state_t state_reg, state_next;
    logic [RCW-1:0]  rcount_reg, rcount_next;
    logic [QAW-1:0]  qhead_reg, qhead_next;
    logic [QCW-1:0]  qcount_reg, qcount_next;
    logic [RCW-1:0]  idx_reg, idx_next;
    logic [2:0]      op_reg, op_next;
    krq_pkg::rec_t   in_reg, in_next;
    krq_pkg::rec_t   res_reg, res_next;
    logic [2:0]      status_reg, status_next;
    logic            mvalid_reg, mvalid_next;

    logic            r_we, q_we;
    logic [RAW-1:0]  r_waddr, r_raddr;
    logic [QAW-1:0]  q_waddr, q_raddr;
    krq_pkg::rec_t   r_wdata, q_wdata, r_rdata, q_rdata;
    logic [RCW-1:0]  idx_inc;
    logic [QAW-1:0]  qhead_dec, qtail;

    krq_ram #(.WIDTH(krq_pkg::RecWidth), .DEPTH(REGISTRY_DEPTH)) u_reg_ram (
        .aclk(aclk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(r_rdata)
    );

    krq_ram #(.WIDTH(krq_pkg::RecWidth), .DEPTH(QUEUE_DEPTH)) u_que_ram (
        .aclk(aclk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    assign idx_inc   = idx_reg + RCW'(1);
    assign qhead_dec = (qhead_reg == '0) ? QAW'(QUEUE_DEPTH - 1) : qhead_reg - QAW'(1);
    always_comb begin
        logic [QAW:0] sum;
        sum = {1'b0, qhead_reg} + (QAW+1)'(qcount_reg);
        if (sum >= (QAW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (QAW+1)'(QUEUE_DEPTH);
        end
        qtail = sum[QAW-1:0];
    end

    assign s_ready      = (state_reg == krq_pkg::S_IDLE) && !mvalid_reg;
    assign m_valid      = mvalid_reg;
    assign m_status     = status_reg;
    assign m_res_id     = res_reg.id;
    assign m_res_source = res_reg.src;
    assign m_res_dest   = res_reg.dst;
    assign m_res_prio   = res_reg.prio;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= krq_pkg::S_IDLE;
            rcount_reg <= '0;
            qhead_reg  <= '0;
            qcount_reg <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rcount_reg <= rcount_next;
            qhead_reg  <= qhead_next;
            qcount_reg <= qcount_next;
            mvalid_reg <= mvalid_next;
        end
        idx_reg    <= idx_next;
        op_reg     <= op_next;
        in_reg     <= in_next;
        res_reg    <= res_next;
        status_reg <= status_next;
    end

    always_comb begin
        state_next  = state_reg;
        rcount_next = rcount_reg;
        qhead_next  = qhead_reg;
        qcount_next = qcount_reg;
        idx_next    = idx_reg;
        op_next     = op_reg;
        in_next     = in_reg;
        res_next    = res_reg;
        status_next = status_reg;
        mvalid_next = mvalid_reg;
        r_we    = 1'b0;
        r_waddr = idx_reg[RAW-1:0];
        r_wdata = in_reg;
        r_raddr = idx_reg[RAW-1:0];
        q_we    = 1'b0;
        q_waddr = qtail;
        q_wdata = r_rdata;
        q_raddr = qhead_reg;

        if (mvalid_reg && m_ready) begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            krq_pkg::S_IDLE: begin
                if (s_valid && s_ready) begin
                    op_next  = s_opcode;
                    in_next  = '{id: s_key_id, src: s_source_loc,
                                 dst: s_dest_loc, prio: s_prio_code};
                    idx_next = '0;
                    res_next = '0;
                    status_next = krq_pkg::ST_OK;
                    case (s_opcode)
                        krq_pkg::OP_ADD: begin
                            if (rcount_reg == RegFull) begin
                                status_next = krq_pkg::ST_REG_FULL;
                            end else begin
                                r_we        = 1'b1;
                                r_waddr     = rcount_reg[RAW-1:0];
                                r_wdata     = '{id: s_key_id, src: s_source_loc,
                                                dst: s_dest_loc, prio: s_prio_code};
                                rcount_next = rcount_reg + RCW'(1);
                            end
                            state_next = krq_pkg::S_DONE;
                        end
                        krq_pkg::OP_SEARCH, krq_pkg::OP_DELETE,
                        krq_pkg::OP_ENQUEUE: begin
                            state_next = krq_pkg::S_SCAN_RD;
                        end
                        krq_pkg::OP_DELIVER: begin
                            if (qcount_reg == '0) begin
                                status_next = krq_pkg::ST_QUEUE_EMPTY;
                                state_next  = krq_pkg::S_DONE;
                            end else begin
                                state_next = krq_pkg::S_QRD;
                            end
                        end
                        default: state_next = krq_pkg::S_DONE;
                    endcase
                end
            end
            krq_pkg::S_SCAN_RD: begin
                // issue read for the current index, or stop at the end
                if (idx_reg >= rcount_reg) begin
                    status_next = krq_pkg::ST_NOT_FOUND;
                    state_next  = krq_pkg::S_DONE;
                end else begin
                    state_next = krq_pkg::S_SCAN_CMP;
                end
            end
            krq_pkg::S_SCAN_CMP: begin
                if (r_rdata.id == in_reg.id) begin
                    case (op_reg)
                        krq_pkg::OP_DELETE: begin
                            res_next   = r_rdata;
                            state_next = krq_pkg::S_SHIFT_RD;
                        end
                        krq_pkg::OP_ENQUEUE: begin
                            if (qcount_reg == QueFull) begin
                                status_next = krq_pkg::ST_QUEUE_FULL;
                            end else begin
                                q_we = 1'b1;
                                res_next = r_rdata;
                                if (r_rdata.prio == krq_pkg::HighPrio) begin
                                    q_waddr    = qhead_dec;
                                    qhead_next = qhead_dec;
                                end
                                qcount_next = qcount_reg + QCW'(1);
                            end
                            state_next = krq_pkg::S_DONE;
                        end
                        default: begin
                            res_next   = r_rdata;
                            state_next = krq_pkg::S_DONE;
                        end
                    endcase
                end else begin
                    idx_next   = idx_inc;
                    state_next = krq_pkg::S_SCAN_RD;
                end
            end
            krq_pkg::S_SHIFT_RD: begin
                // read the record above the gap, or close out the delete
                if (idx_inc >= rcount_reg) begin
                    rcount_next = rcount_reg - RCW'(1);
                    state_next  = krq_pkg::S_DONE;
                end else begin
                    r_raddr    = idx_inc[RAW-1:0];
                    state_next = krq_pkg::S_SHIFT_WR;
                end
            end
            krq_pkg::S_SHIFT_WR: begin
                r_we       = 1'b1;
                r_wdata    = r_rdata;
                idx_next   = idx_inc;
                state_next = krq_pkg::S_SHIFT_RD;
            end
            krq_pkg::S_QRD: begin
                state_next = krq_pkg::S_QWAIT;
            end
            krq_pkg::S_QWAIT: begin
                res_next    = q_rdata;
                qhead_next  = (qhead_reg == QAW'(QUEUE_DEPTH - 1)) ? '0
                                                                  : qhead_reg + QAW'(1);
                qcount_next = qcount_reg - QCW'(1);
                state_next  = krq_pkg::S_DONE;
            end
            krq_pkg::S_DONE: begin
                mvalid_next = 1'b1;
                state_next  = krq_pkg::S_IDLE;
            end
            default: state_next = krq_pkg::S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rcount_reg <= RegFull && qcount_reg <= QueFull)
        else $error("count beyond depth");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("ready while result pending");
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !m_valid)
        else $error("result appeared too early");
    a_done_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == krq_pkg::S_DONE) |=> m_valid)
        else $error("done without result");
`endif

endmodule

FILE: tb/tb_keyed_registry_two_class_queue_unit.sv
// Testbench for the keyed registry and two-class queue unit.
// Holds a registry/deque predictor and result scoreboard, stimulus tasks and a sink;
// depends on krq_pkg and keyed_registry_two_class_queue_unit.
`timescale 1ns / 1ps

class krq_scoreboard;
    krq_pkg::rec_t registry[$];
    krq_pkg::rec_t deque[$];
    krq_pkg::status_t want_status[$];
    krq_pkg::rec_t want_rec[$];
    int errors;

    function new();
        errors = 0;
    endfunction

    function int find_key(logic [15:0] key);
        foreach (registry[i])
            if (registry[i].id == key) return i;
        return -1;
    endfunction

    // Work out the result of one accepted transaction and advance the state.
    function void note_op(logic [2:0] op, krq_pkg::rec_t inp);
        krq_pkg::status_t st;
        krq_pkg::rec_t r;
        int idx;
        st = krq_pkg::ST_OK;
        r = '0;
        case (op)
            krq_pkg::OP_ADD: begin
                if (registry.size() >= 16) st = krq_pkg::ST_REG_FULL;
                else registry.push_back(inp);
            end
            krq_pkg::OP_SEARCH, krq_pkg::OP_DELETE, krq_pkg::OP_ENQUEUE: begin
                idx = find_key(inp.id);
                if (idx < 0) begin
                    st = krq_pkg::ST_NOT_FOUND;
                end else if (op == krq_pkg::OP_SEARCH) begin
                    r = registry[idx];
                end else if (op == krq_pkg::OP_DELETE) begin
                    r = registry[idx];
                    registry.delete(idx);
                end else if (deque.size() >= 16) begin
                    st = krq_pkg::ST_QUEUE_FULL;
                end else begin
                    r = registry[idx];
                    if (r.prio == krq_pkg::HighPrio) deque.push_front(r);
                    else deque.push_back(r);
                end
            end
            krq_pkg::OP_DELIVER: begin
                if (deque.size() == 0) st = krq_pkg::ST_QUEUE_EMPTY;
                else r = deque.pop_front();
            end
            default: ;
        endcase
        want_status.push_back(st);
        want_rec.push_back(r);
    endfunction

    function void check_result(logic [2:0] st, krq_pkg::rec_t got);
        krq_pkg::rec_t w;
        logic [2:0] ws;
        if (want_status.size() == 0) begin
            $display("%0t: unexpected result status %0d", $time, st);
            errors++;
            return;
        end
        ws = want_status.pop_front();
        w = want_rec.pop_front();
        if (st !== ws) begin
            $display("%0t: status expected %0d actual %0d", $time, ws, st);
            errors++;
        end
        if (got.id !== w.id) begin
            $display("%0t: res_id expected %h actual %h", $time, w.id, got.id);
            errors++;
        end
        if (got.src !== w.src) begin
            $display("%0t: res_source expected %h actual %h", $time, w.src, got.src);
            errors++;
        end
        if (got.dst !== w.dst) begin
            $display("%0t: res_dest expected %h actual %h", $time, w.dst, got.dst);
            errors++;
        end
        if (got.prio !== w.prio) begin
            $display("%0t: res_prio expected %0d actual %0d", $time, w.prio, got.prio);
            errors++;
        end
    endfunction
endclass

module tb_keyed_registry_two_class_queue_unit;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_opcode = '0;
    logic [15:0] s_key_id = '0;
    logic [15:0] s_source_loc = '0;
    logic [15:0] s_dest_loc = '0;
    logic [1:0]  s_prio_code = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [15:0] m_res_id;
    logic [15:0] m_res_source;
    logic [15:0] m_res_dest;
    logic [1:0]  m_res_prio;

    krq_scoreboard sb = new();
    int send_idle_pct = 20;
    int recv_idle_pct = 74;
    bit hold_off = 1'b0;
    int quiet_cycles = 0;
    logic [15:0] keys [4];

    keyed_registry_two_class_queue_unit dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Sample both channels at the edge, before any new drive takes effect.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_op(s_opcode, '{s_key_id, s_source_loc, s_dest_loc, s_prio_code});
            if (m_valid && m_ready)
                sb.check_result(m_status, '{m_res_id, m_res_source, m_res_dest, m_res_prio});
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 20000) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_off) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Valid stays high after acceptance until drain() or a later call's idle gap.
    task automatic send_op(logic [2:0] op, logic [15:0] key, logic [15:0] src,
                           logic [15:0] dst, logic [1:0] prio);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_key_id <= key;
        s_source_loc <= src;
        s_dest_loc <= dst;
        s_prio_code <= prio;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_random();
        logic [2:0] op;
        logic [15:0] key;
        int pick;
        pick = $urandom_range(99);
        if (pick < 30) op = krq_pkg::OP_ADD;
        else if (pick < 45) op = krq_pkg::OP_SEARCH;
        else if (pick < 60) op = krq_pkg::OP_DELETE;
        else if (pick < 78) op = krq_pkg::OP_ENQUEUE;
        else if (pick < 96) op = krq_pkg::OP_DELIVER;
        else op = 3'($urandom_range(7, 5));
        // mostly reuse a small key set so lookups hit
        key = ($urandom_range(9) < 8) ? keys[$urandom_range(3)] : 16'($urandom);
        send_op(op, key, 16'($urandom), 16'($urandom), 2'($urandom));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.want_status.size() != 0) @(posedge aclk);
    endtask

    initial begin
        keys = '{16'h0000, 16'hFFFF, 16'h1234, 16'hA5A5};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty cases, extremes, duplicates, both priority classes
        send_op(krq_pkg::OP_DELIVER, 16'h0000, 16'h0000, 16'h0000, 2'd0);
        send_op(krq_pkg::OP_SEARCH, 16'hFFFF, 16'h0000, 16'h0000, 2'd0);
        send_op(krq_pkg::OP_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3);
        send_op(krq_pkg::OP_ADD, 16'h0000, 16'h0000, 16'h0000, 2'd0);
        send_op(krq_pkg::OP_ADD, 16'hFFFF, 16'h5555, 16'hAAAA, 2'd1);
        send_op(krq_pkg::OP_ADD, 16'h1234, 16'hAAAA, 16'h5555, 2'd2);
        send_op(krq_pkg::OP_SEARCH, 16'hFFFF, 16'h0000, 16'h0000, 2'd0);
        send_op(krq_pkg::OP_ENQUEUE, 16'h1234, 16'h0000, 16'h0000, 2'd0);
        send_op(krq_pkg::OP_ENQUEUE, 16'hFFFF, 16'h0000, 16'h0000, 2'd0);
        send_op(krq_pkg::OP_DELETE, 16'hFFFF, 16'h0000, 16'h0000, 2'd0);
        send_op(krq_pkg::OP_ENQUEUE, 16'hFFFF, 16'h0000, 16'h0000, 2'd0);
        send_op(krq_pkg::OP_ENQUEUE, 16'h0000, 16'h0000, 16'h0000, 2'd0);
        send_op(krq_pkg::OP_ENQUEUE, 16'h7777, 16'h0000, 16'h0000, 2'd0);
        send_op(krq_pkg::OP_DELETE, 16'h7777, 16'h0000, 16'h0000, 2'd0);
        send_op(3'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3);
        send_op(3'd7, 16'h0000, 16'h0000, 16'h0000, 2'd0);
        repeat (17) send_op(krq_pkg::OP_ADD, 16'hFFFF, 16'($urandom), 16'($urandom),
                            2'($urandom));
        repeat (17) send_op(krq_pkg::OP_ENQUEUE, 16'hFFFF, 16'h0, 16'h0, 2'd0);
        repeat (18) send_op(krq_pkg::OP_DELIVER, 16'h0, 16'h0, 16'h0, 2'd0);
        repeat (16) send_op(krq_pkg::OP_DELETE, 16'hFFFF, 16'h0, 16'h0, 2'd0);

        // hold the receiver off while offers keep coming, to stall the input
        hold_off = 1'b1;
        fork
            repeat (6) send_random();
            repeat (300) @(posedge aclk);
        join_any
        hold_off = 1'b0;
        wait fork;

        repeat (100) send_random();
        drain();
        send_idle_pct = 74;
        recv_idle_pct = 20;
        repeat (100) send_random();
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (100) send_random();
        drain();
        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.want_status.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
